/* design/etp_pkg.sv */
`default_nettype none
package etp_pkg;

    localparam int VAL_W        = 48;
    localparam int FRAC_BITS    = 42;
    localparam int STEP_W       = 47;
    localparam int STRIDE_W     = 14;
    localparam int BPP_W        = 6;
    localparam int PIX_W        = 10;
    localparam int CNT_W        = 7;
    localparam int GRAY_W       = 8;
    localparam int ADDR_W       = 24;
    localparam int IDX_W        = 3;
    localparam int IMAGE_WIDTH  = 800;
    localparam int IMAGE_HEIGHT = 600;
    localparam int ITER_LIMIT   = 100;

    // magnitude split for the shared 24 x 48 partial products
    localparam int HALF_W    = VAL_W / 2;
    localparam int PART_W    = HALF_W + VAL_W;
    localparam int FULL_W    = 2 * VAL_W;
    localparam int MAG_W     = FULL_W - FRAC_BITS;
    localparam int PROD_W    = MAG_W + 1;
    localparam int WIDE_W    = 60;
    localparam int NUM_LANES = 5;

    // gray = floor(count * 255 / ITER_LIMIT) as (count * GRAY_MUL) >> GRAY_SHIFT
    localparam int GRAY_SHIFT = 16;
    localparam int GRAY_MUL   = (255 * (1 << GRAY_SHIFT) + ITER_LIMIT - 1) / ITER_LIMIT;
    localparam int GRAY_PW    = CNT_W + 18;

    typedef enum logic [IDX_W-1:0] {
        REG_STEP_X,
        REG_STEP_Y,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_LINE_STRIDE,
        REG_BITS_PER_PIXEL
    } etp_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PROD,
        ST_CHECK,
        ST_DONE
    } etp_state_t;

    typedef struct packed {
        logic        [STEP_W-1:0]   step_x;
        logic        [STEP_W-1:0]   step_y;
        logic signed [VAL_W-1:0]    offset_x;
        logic signed [VAL_W-1:0]    offset_y;
        logic signed [VAL_W-1:0]    offset_z;
        logic        [STRIDE_W-1:0] line_stride;
        logic        [BPP_W-1:0]    bits_per_pixel;
    } etp_cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  cx;
        logic signed [VAL_W-1:0]  cy;
        logic        [ADDR_W-1:0] addr;
    } etp_job_t;

    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v[WIDE_W-1:VAL_W-1] == {(WIDE_W-VAL_W+1){1'b0}} ||
            v[WIDE_W-1:VAL_W-1] == {(WIDE_W-VAL_W+1){1'b1}})
            r = v[VAL_W-1:0];
        else
            r = {v[WIDE_W-1], {(VAL_W-1){~v[WIDE_W-1]}}};
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/etp_pixel_if.sv */
`default_nettype none
interface etp_pixel_if
    import etp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;

    modport source(output valid, pixel_x, pixel_y, input ready);
    modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface
`default_nettype wire

/* design/etp_result_if.sv */
`default_nettype none
interface etp_result_if
    import etp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  iteration_count;
    logic [GRAY_W-1:0] gray_level;
    logic [ADDR_W-1:0] byte_address;

    modport source(output valid, iteration_count, gray_level, byte_address, input ready);
    modport sink(input valid, iteration_count, gray_level, byte_address, output ready);
endinterface
`default_nettype wire

/* design/etp_cfg_if.sv */
`default_nettype none
interface etp_cfg_if
    import etp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/three_dim_escape_time_pixel.sv */
`default_nettype none
// Escape-time engine for a 3-D Mandelbrot-style slice, one pixel at a time.
// pixel (sink): one transaction per pixel (pixel_x, pixel_y). The front stage
//   registers it, maps it to c = (cx, cy, offset_z) and the byte address and
//   parks the job in a two-entry queue.
// result (source): one transaction per pixel, in input order: iteration_count,
//   gray_level (count * 255 / 100) and byte_address.
// cfg (sink): register writes (index, data), always ready; write only while
//   no pixel is in flight.
// Each iteration in the back engine runs partial products, combine and
//   update/escape test (ST_MUL, ST_PROD, ST_CHECK), plus one pass for the first
//   squares. A pixel ends when it escapes or reaches the limit of 100 iterations.
//   The five shared 24x48 multiplier lanes set the pace of each iteration; the
//   engine starts the next pixel only after the previous one has left ST_DONE.
// Reset: the queue and both stages empty, registers return to their defaults.
// A stalled receiver holds the result register; the engine finishes the next
//   pixel and waits, and the queue keeps taking pixels until it fills.
module three_dim_escape_time_pixel
    import etp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    etp_pixel_if.sink    pixel,
    etp_result_if.source result,
    etp_cfg_if.sink      cfg
);

    etp_cfg_t cfg_reg;
    etp_job_t push_data, pop_data;
    logic     push, pop, q_full, q_not_empty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_x         <= STEP_W'(64'd10995116278);
            cfg_reg.step_y         <= STEP_W'(64'd14660155037);
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_y       <= '0;
            cfg_reg.offset_z       <= '0;
            cfg_reg.line_stride    <= STRIDE_W'(3200);
            cfg_reg.bits_per_pixel <= BPP_W'(32);
        end
        else if (cfg.valid)
        begin
            unique case (etp_reg_t'(cfg.index))
                REG_STEP_X:         cfg_reg.step_x         <= cfg.data[STEP_W-1:0];
                REG_STEP_Y:         cfg_reg.step_y         <= cfg.data[STEP_W-1:0];
                REG_OFFSET_X:       cfg_reg.offset_x       <= cfg.data;
                REG_OFFSET_Y:       cfg_reg.offset_y       <= cfg.data;
                REG_OFFSET_Z:       cfg_reg.offset_z       <= cfg.data;
                REG_LINE_STRIDE:    cfg_reg.line_stride    <= cfg.data[STRIDE_W-1:0];
                REG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= cfg.data[BPP_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    etp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pixel     (pixel),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    etp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    etp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .result      (result)
    );

endmodule
`default_nettype wire

/* design/etp_queue.sv */
`default_nettype none
module etp_queue
    import etp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire etp_job_t push_data,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output etp_job_t      pop_data
);

    etp_job_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* design/etp_front.sv */
`default_nettype none
module etp_front
    import etp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire etp_cfg_t cfg,
    etp_pixel_if.sink     pixel,
    input  wire logic     q_full,
    output logic          push,
    output etp_job_t      push_data
);

    logic             hold_reg, hold_next;
    logic [PIX_W-1:0] px_reg, py_reg;

    logic signed [PIX_W+1:0]  dx, dy;
    logic signed [WIDE_W-1:0] prod_x, prod_y;
    logic signed [WIDE_W-1:0] sum_x, sum_y;
    logic [PIX_W+BPP_W-1:0]   x_bits;
    logic [ADDR_W-1:0]        y_bytes;

    assign push        = hold_reg && !q_full;
    assign pixel.ready = !hold_reg || push;

    // centered pixel times step, halved with floor, plus offset
    always_comb
    begin
        dx     = $signed({1'b0, px_reg, 1'b0}) - (PIX_W+2)'(IMAGE_WIDTH);
        dy     = $signed({1'b0, py_reg, 1'b0}) - (PIX_W+2)'(IMAGE_HEIGHT);
        prod_x = WIDE_W'(dx) * WIDE_W'($signed({1'b0, cfg.step_x}));
        prod_y = WIDE_W'(dy) * WIDE_W'($signed({1'b0, cfg.step_y}));
        sum_x  = (prod_x >>> 1) + WIDE_W'(cfg.offset_x);
        sum_y  = (prod_y >>> 1) + WIDE_W'(cfg.offset_y);
        x_bits  = (PIX_W+BPP_W)'(px_reg) * (PIX_W+BPP_W)'(cfg.bits_per_pixel);
        y_bytes = ADDR_W'(py_reg) * ADDR_W'(cfg.line_stride);
        push_data.cx   = sat48(sum_x);
        push_data.cy   = sat48(sum_y);
        push_data.addr = ADDR_W'(x_bits[PIX_W+BPP_W-1:3]) + y_bytes;
        hold_next      = (pixel.valid && pixel.ready) || (hold_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else
            hold_reg <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            px_reg <= pixel.pixel_x;
            py_reg <= pixel.pixel_y;
        end
    end

endmodule
`default_nettype wire

/* design/etp_back.sv */
`default_nettype none
module etp_back
    import etp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire etp_cfg_t cfg,
    input  wire logic     q_not_empty,
    input  wire etp_job_t q_data,
    output logic          pop,
    etp_result_if.source  result
);

    etp_state_t state_reg, state_next;

    logic signed [VAL_W-1:0]  cx_reg, cy_reg;
    logic signed [VAL_W-1:0]  zx_reg, zy_reg, zz_reg;
    logic        [ADDR_W-1:0] addr_reg;
    logic        [CNT_W-1:0]  count_reg, count_next;
    logic                     first_reg;
    logic        [PART_W-1:0] plo_reg [NUM_LANES];
    logic        [PART_W-1:0] phi_reg [NUM_LANES];
    logic                     neg_reg [NUM_LANES];
    logic signed [PROD_W-1:0] prod_reg [NUM_LANES];

    logic res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]  res_count_reg;
    logic [GRAY_W-1:0] res_gray_reg;
    logic [ADDR_W-1:0] res_addr_reg;

    logic load_job, do_mul, do_prod, do_update, do_count, load_res;

    logic signed [VAL_W-1:0]  op_a [NUM_LANES];
    logic signed [VAL_W-1:0]  op_b [NUM_LANES];
    logic        [VAL_W-1:0]  mag_a [NUM_LANES];
    logic        [VAL_W-1:0]  mag_b [NUM_LANES];
    logic        [FULL_W-1:0] full [NUM_LANES];
    logic        [MAG_W-1:0]  mag_p [NUM_LANES];
    logic signed [PROD_W-1:0] prod_next [NUM_LANES];
    logic signed [WIDE_W-1:0] new_x, new_y, new_z, esc_sum;
    logic                     escaped, last_iter;
    logic        [GRAY_PW-1:0] gray_prod;

    // lanes: zx^2, zy^2, zz^2, zx*zy, zx*zz
    always_comb
    begin
        op_a[0] = zx_reg; op_b[0] = zx_reg;
        op_a[1] = zy_reg; op_b[1] = zy_reg;
        op_a[2] = zz_reg; op_b[2] = zz_reg;
        op_a[3] = zx_reg; op_b[3] = zy_reg;
        op_a[4] = zx_reg; op_b[4] = zz_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mag_a[i] = op_a[i][VAL_W-1] ? -op_a[i] : op_a[i];
            mag_b[i] = op_b[i][VAL_W-1] ? -op_b[i] : op_b[i];
            full[i]  = {{(FULL_W-PART_W){1'b0}}, plo_reg[i]}
                       + {phi_reg[i], {HALF_W{1'b0}}};
            mag_p[i] = full[i][FULL_W-1:FRAC_BITS];
            prod_next[i] = neg_reg[i] ? -$signed({1'b0, mag_p[i]}) : $signed({1'b0, mag_p[i]});
        end
    end

    always_comb
    begin
        esc_sum = WIDE_W'(prod_reg[0]) + WIDE_W'(prod_reg[1]) + WIDE_W'(prod_reg[2]);
        escaped = esc_sum > (WIDE_W'(1) <<< (FRAC_BITS + 2));
        new_x   = WIDE_W'(prod_reg[0]) - WIDE_W'(prod_reg[1]) - WIDE_W'(prod_reg[2])
                  + WIDE_W'(cx_reg);
        new_y   = (WIDE_W'(prod_reg[3]) <<< 1) + WIDE_W'(cy_reg);
        new_z   = (WIDE_W'(prod_reg[4]) <<< 1) + WIDE_W'(cfg.offset_z);
        last_iter = (count_reg + CNT_W'(1)) == CNT_W'(ITER_LIMIT);
        gray_prod = GRAY_PW'(count_reg) * GRAY_PW'(GRAY_MUL);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_not_empty)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_PROD;
            ST_PROD:
                state_next = ST_CHECK;
            ST_CHECK:
                if (first_reg)
                    state_next = ST_MUL;
                else if (escaped || last_iter)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            ST_DONE:
                if (!res_valid_reg || result.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load_job  = 1'b0;
        do_mul    = 1'b0;
        do_prod   = 1'b0;
        do_update = 1'b0;
        do_count  = 1'b0;
        load_res  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  load_job = q_not_empty;
            ST_MUL:   do_mul   = 1'b1;
            ST_PROD:  do_prod  = 1'b1;
            ST_CHECK:
            begin
                do_update = first_reg || (!escaped && !last_iter);
                do_count  = !first_reg && !escaped;
            end
            ST_DONE:  load_res = !res_valid_reg || result.ready;
            default:  load_job = 1'b0;
        endcase
    end

    assign pop = load_job;

    always_comb
    begin
        count_next = count_reg;
        if (load_job)
            count_next = '0;
        else if (do_count)
            count_next = count_reg + CNT_W'(1);
        res_valid_next = load_res || (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        if (load_job)
        begin
            cx_reg    <= q_data.cx;
            cy_reg    <= q_data.cy;
            zx_reg    <= q_data.cx;
            zy_reg    <= q_data.cy;
            zz_reg    <= cfg.offset_z;
            addr_reg  <= q_data.addr;
            first_reg <= 1'b1;
        end
        else if (do_update)
        begin
            zx_reg    <= sat48(new_x);
            zy_reg    <= sat48(new_y);
            zz_reg    <= sat48(new_z);
            first_reg <= 1'b0;
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (do_mul)
            begin
                plo_reg[i] <= PART_W'(mag_a[i][HALF_W-1:0]) * PART_W'(mag_b[i]);
                phi_reg[i] <= PART_W'(mag_a[i][VAL_W-1:HALF_W]) * PART_W'(mag_b[i]);
                neg_reg[i] <= op_a[i][VAL_W-1] ^ op_b[i][VAL_W-1];
            end
            if (do_prod)
                prod_reg[i] <= prod_next[i];
        end
        if (load_res)
        begin
            res_count_reg <= count_reg;
            res_gray_reg  <= gray_prod[GRAY_SHIFT+GRAY_W-1:GRAY_SHIFT];
            res_addr_reg  <= addr_reg;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.iteration_count = res_count_reg;
    assign result.gray_level      = res_gray_reg;
    assign result.byte_address    = res_addr_reg;

endmodule
`default_nettype wire
